// ===== rtl/core/ternary_pattern_match_table_macros.svh =====
// Assertion macros used by the ternary pattern match table RTL.
`ifndef TERNARY_PATTERN_MATCH_TABLE_MACROS_SVH
`define TERNARY_PATTERN_MATCH_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TPMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tpmt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tpmt assertion failed");

`else

`define TPMT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TPMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/tpmt_pkg.sv =====
`timescale 1ns / 1ps

package tpmt_pkg;

    localparam int ENTRIES      = 256;
    localparam int PATTERN_BITS = 128;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WIDTH_W      = 8;
    localparam int HALF_W       = 64;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd128;

    // operation codes carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [PATTERN_BITS-1:0] pattern_t;

    // one stored entry: disallowed mask above required mask
    typedef struct packed {
        pattern_t disallowed;
        pattern_t required;
    } entry_t;

    // scan control from the sequencer to the match unit
    typedef struct packed {
        logic clear;
        logic compare;
    } scan_ctl_t;

endpackage

// ===== rtl/core/tpmt_pattern_ram.sv =====
`timescale 1ns / 1ps

module tpmt_pattern_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tpmt_match.sv =====
`timescale 1ns / 1ps

module tpmt_match
    import tpmt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  scan_ctl_t ctl,
    input  entry_t    entry,
    input  pattern_t  query,
    input  pattern_t  void_mask,
    output logic      hit
);

    logic hit_reg;
    logic hit_next;
    logic entry_ok;

    // required bits all present; disallowed bits absent from query and void zone
    assign entry_ok = ((entry.required & ~query) == '0) &&
                      ((entry.disallowed & (query | void_mask)) == '0);

    always_comb begin
        hit_next = hit_reg;
        if (ctl.clear) begin
            hit_next = 1'b0;
        end else if (ctl.compare && entry_ok) begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== rtl/core/ternary_pattern_match_table.sv =====
`timescale 1ns / 1ps
//  channel   dir  handshake                payload
//  s_        in   s_tvalid / s_tready      s_tuser operation, s_tdata entry and query fields
//  m_        out  m_tvalid / m_tready      m_tdata match_found
//  cfg_      in   cfg_wr_en (no wait)      cfg_wr_data width_in_use
//
//  Write item: result lands in the output register at the same edge that accepts it.
//  Query item: the sequencer runs ST_SCAN, ST_DRAIN, then ST_DONE, which loads the result
//  register once the output is free; the scan uses the single RAM read port, one entry per cycle.
//  One item is in flight at a time; s_tready drops during a scan.
//  A waiting result does not block a new item once m_tready is high in the same cycle.
//  Reset (aresetn low, synchronous) clears all entry valid bits at once and sets
//  width_in_use to 128; no clearing pass is needed.

`include "ternary_pattern_match_table_macros.svh"

module ternary_pattern_match_table
    import tpmt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [WIDTH_W-1:0] cfg_wr_data,   // [7:0] width_in_use

    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [0:0]         s_tuser,       // [0] operation
    // [7:0] entry_index, [8] entry_valid, [72:9] required_low_half,
    // [136:73] required_high_half, [200:137] disallowed_low_half,
    // [264:201] disallowed_high_half, [328:265] query_low_half,
    // [392:329] query_high_half, [399:393] zero
    input  logic [399:0]       s_tdata,

    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata        // [0] match_found, [7:1] zero
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // ---------------- input unpacking ----------------
    logic [7:0]             in_index;
    logic                   in_valid_flag;
    logic [2*HALF_W-1:0]    in_req_full;
    logic [2*HALF_W-1:0]    in_dis_full;
    logic [2*HALF_W-1:0]    in_qry_full;

    assign in_index      = s_tdata[7:0];
    assign in_valid_flag = s_tdata[8];
    assign in_req_full   = s_tdata[136:9];
    assign in_dis_full   = s_tdata[264:137];
    assign in_qry_full   = s_tdata[392:265];

    // ---------------- registers ----------------
    state_t             state_reg, state_next;
    logic [WIDTH_W-1:0] width_reg;
    logic [ENTRIES-1:0] valid_bits_reg, valid_bits_next;
    logic [IDX_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               cmp_pend_reg, cmp_pend_next;   // RAM data due this cycle
    logic               rd_vld_reg, rd_vld_next;       // valid bit of the entry read
    pattern_t           query_reg, query_next;
    pattern_t           void_reg, void_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_match_reg, m_match_next;

    // ---------------- datapath wires ----------------
    logic               accept;
    logic               out_free;
    logic               idx_ok;
    logic [IDX_W-1:0]   wr_addr;
    logic               ram_wr_en;
    logic               ram_rd_en;
    entry_t             wr_entry;
    entry_t             rd_entry;
    scan_ctl_t          scan_ctl;
    logic               hit;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // index beyond the table is dropped
    assign idx_ok    = (32'(in_index) < ENTRIES);
    assign wr_addr   = IDX_W'(in_index);
    assign ram_wr_en = accept && (s_tuser[0] == OP_WRITE) && in_valid_flag && idx_ok;
    assign ram_rd_en = (state_reg == ST_SCAN);

    assign wr_entry.required   = in_req_full[PATTERN_BITS-1:0];
    assign wr_entry.disallowed = in_dis_full[PATTERN_BITS-1:0];

    assign scan_ctl.clear   = accept && (s_tuser[0] == OP_QUERY);
    assign scan_ctl.compare = cmp_pend_reg && rd_vld_reg;

    tpmt_pattern_ram #(
        .DEPTH  (ENTRIES),
        .WIDTH  ($bits(entry_t)),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_cnt_reg),
        .rd_data (rd_entry)
    );

    tpmt_match u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .entry     (rd_entry),
        .query     (query_reg),
        .void_mask (void_reg),
        .hit       (hit)
    );

    // width register: the user must write it only while idle; the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        valid_bits_next = valid_bits_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_pend_next   = 1'b0;
        rd_vld_next     = rd_vld_reg;
        query_next      = query_reg;
        void_next       = void_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_match_next    = m_match_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == OP_WRITE) begin
                        if (idx_ok) begin
                            valid_bits_next[wr_addr] = in_valid_flag;
                        end
                        m_valid_next = 1'b1;
                        m_match_next = 1'b0;
                    end else begin
                        query_next    = in_qry_full[PATTERN_BITS-1:0];
                        // bits at or above the width in use void a disallowed mask
                        for (int i = 0; i < PATTERN_BITS; i++) begin
                            void_next[i] = (i >= int'(width_reg));
                        end
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmp_pend_next = 1'b1;
                rd_vld_next   = valid_bits_reg[scan_cnt_reg];
                if (scan_cnt_reg == IDX_W'(ENTRIES - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // last entry compared this cycle
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_match_next = hit;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_bits_reg <= '0;
            scan_cnt_reg   <= '0;
            cmp_pend_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_bits_reg <= valid_bits_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_pend_reg   <= cmp_pend_next;
            rd_vld_reg     <= rd_vld_next;
            m_valid_reg    <= m_valid_next;
        end
        query_reg   <= query_next;
        void_reg    <= void_next;
        m_match_reg <= m_match_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_match_reg};

    // ---------------- checks ----------------
    `TPMT_ASSERT_NEXT(a_query_starts_scan, aclk, aresetn, accept && (s_tuser[0] == OP_QUERY), (state_reg == ST_SCAN) && (scan_cnt_reg == '0))
    `TPMT_ASSERT_NEXT(a_write_result_zero, aclk, aresetn, accept && (s_tuser[0] == OP_WRITE), m_tvalid && (m_tdata[0] == 1'b0))
    `TPMT_ASSERT_NOW(a_busy_no_ready, aclk, aresetn, (state_reg != ST_IDLE), !s_tready && !ram_wr_en)
    `TPMT_ASSERT_NEXT(a_drain_after_last, aclk, aresetn, (state_reg == ST_SCAN) && (scan_cnt_reg == IDX_W'(ENTRIES - 1)), (state_reg == ST_DRAIN) && cmp_pend_reg)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tpmt_pkg::*;

    typedef struct {
        logic       op;
        logic [7:0] idx;
        logic       valid;
        pattern_t   req;
        pattern_t   dis;
        pattern_t   q;
    } tbl_item_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [WIDTH_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [0:0]         s_tuser = '0;
    logic [399:0]       s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;

    ternary_pattern_match_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor copy of the table and the width register
    logic [WIDTH_W-1:0] width_model = WIDTH_RESET;
    logic               present_model [ENTRIES];
    pattern_t           req_model [ENTRIES];
    pattern_t           dis_model [ENTRIES];

    tbl_item_t pending_items [$];
    logic      expected_match_q [$];
    int        mismatch_count = 0;

    initial begin
        for (int i = 0; i < ENTRIES; i++) present_model[i] = 1'b0;
    end

    function automatic pattern_t rand_pattern();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // roughly one bit in eight set
    function automatic pattern_t sparse_pattern();
        return rand_pattern() & rand_pattern() & rand_pattern();
    endfunction

    // biased toward a few low entries so overwrites and invalidations hit live data
    function automatic logic [7:0] rand_index();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic lookup_hit(pattern_t q);
        pattern_t void_bits;
        logic     hit;
        hit = 1'b0;
        if (width_model >= PATTERN_BITS) void_bits = '0;
        else void_bits = ~((pattern_t'(1) << width_model) - pattern_t'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            if (present_model[i] && ((req_model[i] & ~q) == '0) && ((dis_model[i] & q) == '0)
                && ((dis_model[i] & void_bits) == '0)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic apply_item(tbl_item_t it);
        if (it.op == OP_WRITE) begin
            if (it.valid) begin
                present_model[it.idx] = 1'b1;
                req_model[it.idx]     = it.req;
                dis_model[it.idx]     = it.dis;
            end else begin
                // masks stay as they were
                present_model[it.idx] = 1'b0;
            end
            expected_match_q = {expected_match_q, 1'b0};
        end else begin
            expected_match_q = {expected_match_q, lookup_hit(it.q)};
        end
    endtask

    // ---------------- driver: bursts with random gaps ----------------
    tbl_item_t drv_item;
    int        burst_left = 1;
    int        gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) apply_item(drv_item);
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                drv_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_item.op;
                s_tdata  <= {7'b0, drv_item.q, drv_item.dis, drv_item.req,
                             drv_item.valid, drv_item.idx};
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor: stall pattern, compare ----------------
    logic [15:0] stall_pat = 16'hffff;
    logic [7:0]  stall_tick = '0;
    logic        want_match;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_match_q.size() == 0) begin
                    $error("unexpected result item: match_found=%0b", m_tdata[0]);
                    mismatch_count++;
                end else begin
                    want_match = expected_match_q.pop_front();
                    if (m_tdata[0] !== want_match) begin
                        $error("match_found mismatch: expected %0b, actual %0b",
                               want_match, m_tdata[0]);
                        mismatch_count++;
                    end
                end
            end
            stall_tick <= stall_tick + 8'd1;
            if (stall_tick == 8'hff)
                stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff
                                                         : (16'($urandom) | 16'h0001);
            m_tready <= stall_pat[stall_tick[3:0]];
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_write(logic [7:0] idx, logic valid, pattern_t req, pattern_t dis);
        tbl_item_t it;
        it.op    = OP_WRITE;
        it.idx   = idx;
        it.valid = valid;
        it.req   = req;
        it.dis   = dis;
        it.q     = rand_pattern();
        pending_items = {pending_items, it};
    endtask

    task automatic push_query(pattern_t q);
        tbl_item_t it;
        it.op    = OP_QUERY;
        it.idx   = 8'($urandom);
        it.valid = 1'($urandom);
        it.req   = rand_pattern();
        it.dis   = rand_pattern();
        it.q     = q;
        pending_items = {pending_items, it};
    endtask

    task automatic push_random();
        pattern_t   q;
        logic [7:0] idx;
        int         style;
        style = $urandom_range(0, 99);
        if (style < 45) begin
            idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : rand_index();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_write(idx, 1'b1, sparse_pattern(), sparse_pattern());
                4, 5:       push_write(idx, 1'b1, sparse_pattern(), '0);
                6:          push_write(idx, 1'b1, '0,
                                       sparse_pattern() & ((pattern_t'(1) <<
                                       $urandom_range(1, 127)) - pattern_t'(1)));
                7:          push_write(idx, 1'b1, rand_pattern(), rand_pattern());
                default:    push_write(idx, 1'b0, rand_pattern(), rand_pattern());
            endcase
        end else begin
            case ($urandom_range(0, 9))
                0: q = '1;
                1: q = '0;
                2: q = rand_pattern();
                3: q = sparse_pattern();
                default: begin
                    // built around a live entry: hits unless the width voids it, a bit is flipped or none is found
                    idx = rand_index();
                    for (int t = 0; t < 8 && !present_model[idx]; t++) idx = rand_index();
                    q = req_model[idx] | (sparse_pattern() & ~dis_model[idx]);
                    if (!present_model[idx]) q = sparse_pattern();
                    if ($urandom_range(0, 3) == 0) q ^= pattern_t'(1) << $urandom_range(0, 127);
                end
            endcase
            push_query(q);
        end
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) begin
            while (pending_items.size() >= 4) @(negedge aclk);
            push_random();
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_match_q.size() != 0);
    endtask

    task automatic write_width(logic [WIDTH_W-1:0] w);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        width_model = w;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    int phase_width [10] = '{0, 1, 63, 64, 65, 127, 128, 255, 129, -1};

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table answers no match
        push_query('1);
        push_query('0);
        // entry needing every bit
        push_write(8'd0, 1'b1, '1, '0);
        push_query('1);
        push_query({1'b0, {127{1'b1}}});
        // entry forbidding every bit, at the top index
        push_write(8'd255, 1'b1, '0, '1);
        push_query('0);
        // invalidate: masks supplied are ignored
        push_write(8'd0, 1'b0, rand_pattern(), rand_pattern());
        push_query('1);
        push_write(8'd0, 1'b1, pattern_t'(1), pattern_t'(1) << 127);
        push_query(pattern_t'(1));
        push_write(8'd255, 1'b0, '0, '0);
        push_query('0);
        push_query(pattern_t'(1));
        push_query(pattern_t'(1) | (pattern_t'(1) << 127));

        run_random(60);
        for (int p = 0; p < 10; p++) begin
            wait_idle();
            if (phase_width[p] < 0) write_width(8'($urandom_range(2, 126)));
            else write_width(8'(phase_width[p]));
            // the top-bit entry is voided for every width below the pattern size
            push_query(pattern_t'(1));
            push_query('0);
            run_random(76);
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && expected_match_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tpmt_pkg.sv
rtl/core/tpmt_pattern_ram.sv
rtl/core/tpmt_match.sv
rtl/core/ternary_pattern_match_table.sv
tb/testbench.sv
